[rtl/matrix_multiply_defines.svh]
// Assertion macros used by the matrix multiply top level.
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and switched off during reset.
`define MM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off during reset.
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/matmul_pkg.sv]
// Types, codes and constants of the matrix multiply block.
`default_nettype none

package matmul_pkg;

  // Default sizes of the element stores and of one element.
  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  // Fixed widths of the word fields.
  localparam int OP_W    = 2;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;
  localparam int VALUE_W = 16;
  localparam int PROD_W  = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET = CFG_DATA_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_LOAD_A  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_LOAD_B  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_COMPUTE = OP_W'(2);

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [ROW_W-1:0]          elem_row;
    logic [COL_W-1:0]          elem_col;
    logic signed [VALUE_W-1:0] elem_value;
  } in_word_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product_value;
    logic [ROW_W-1:0]         out_row;
    logic [COL_W-1:0]         out_col;
    logic                     last;
  } out_word_t;

  // Control that travels alongside one multiply-accumulate step.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tag_t;

  // Status of the multiply-accumulate datapath towards the sequencer.
  typedef struct packed {
    logic stall;
    logic busy;
  } mac_status_t;

endpackage

`default_nettype wire

[rtl/matmul_mac.sv]
// Multiply-accumulate datapath with saturation and the result register.
`default_nettype none

module matmul_mac #(
  parameter int MAX_DIM    = matmul_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = matmul_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire matmul_pkg::tag_t             tag_i,
  input  wire logic signed [ELEM_WIDTH-1:0] a_i,
  input  wire logic signed [ELEM_WIDTH-1:0] b_i,
  output matmul_pkg::mac_status_t           status_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output matmul_pkg::out_word_t             out_data_o
);
  import matmul_pkg::*;

  localparam int MUL_W = 2 * ELEM_WIDTH;
  localparam int ACC_W = MUL_W + $clog2(MAX_DIM) + 1;
  localparam int SAT_W = (ACC_W > 32) ? ACC_W : 33;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sh0000_0000_8000_0000);

  tag_t                    s2_tag_q;
  tag_t                    s3_tag_q;
  logic signed [MUL_W-1:0] prod_q;
  logic signed [MUL_W-1:0] prod_d;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [SAT_W-1:0] acc_ext;
  logic signed [PROD_W-1:0] sat_value;
  logic                    out_valid_q;
  out_word_t               out_data_q;
  logic                    stall;

  // The whole pipe freezes while a finished result waits to be taken.
  assign stall = out_valid_q & ~out_ready_i;

  // Exact product of one pair of elements.
  assign prod_d = MUL_W'(a_i) * MUL_W'(b_i);

  // Running sum, restarted on the first step of each dot product.
  always_comb begin
    if (s2_tag_q.first) begin
      acc_d = ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // Clip the finished sum into signed Q16.16.
  always_comb begin
    acc_ext = SAT_W'(acc_q);
    if (acc_ext > SAT_HI) begin
      sat_value = PROD_W'(SAT_HI);
    end else if (acc_ext < SAT_LO) begin
      sat_value = PROD_W'(SAT_LO);
    end else begin
      sat_value = PROD_W'(acc_ext);
    end
  end

  // Stage control and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_tag_q    <= '0;
      s3_tag_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      s2_tag_q    <= tag_i;
      s3_tag_q    <= s2_tag_q;
      out_valid_q <= s3_tag_q.valid & s3_tag_q.last_k;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      prod_q <= prod_d;
      if (s2_tag_q.valid) begin
        acc_q <= acc_d;
      end
      if (s3_tag_q.valid && s3_tag_q.last_k) begin
        out_data_q.product_value <= sat_value;
        out_data_q.out_row       <= s3_tag_q.row;
        out_data_q.out_col       <= s3_tag_q.col;
        out_data_q.last          <= s3_tag_q.last;
      end
    end
  end

  assign status_o.stall = stall;
  assign status_o.busy  = s2_tag_q.valid | s3_tag_q.valid;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

`default_nettype wire

[rtl/matrix_multiply.sv]
// Matrix multiply: the block holds A and B in two element memories, loads them one element
// per word, and on a compute word streams the product A*B out in row-major order. A load
// word is taken every cycle while no sweep runs or drains. A compute word holds off further
// input until its rows_a*inner_dim*cols_b steps are issued and drained; the single read
// port of each memory and the one multiplier give one multiply-accumulate step per cycle
// while the output is not stalled, and one result per dot product. A size of 0 counts as 1, and
// a size above MAX_DIM counts as MAX_DIM. Loads outside the store and unknown operations
// are dropped. The memories are not cleared: only elements that were loaded may be used.
`default_nettype none

module matrix_multiply #(
  parameter int MAX_DIM    = matmul_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = matmul_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [matmul_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [matmul_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire matmul_pkg::in_word_t              in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output matmul_pkg::out_word_t                  out_data_o
);
  import matmul_pkg::*;

  `include "matrix_multiply_defines.svh"

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [CFG_DATA_W-1:0] rows_a_q;
  logic [CFG_DATA_W-1:0] inner_dim_q;
  logic [CFG_DATA_W-1:0] cols_b_q;

  logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];
  logic signed [ELEM_WIDTH-1:0] rd_a_q;
  logic signed [ELEM_WIDTH-1:0] rd_b_q;
  logic signed [ELEM_WIDTH-1:0] wr_value;

  logic             in_accept;
  logic             busy;
  logic [31:0]      wr_full;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_in_range;
  logic [31:0]      rd_a_full;
  logic [31:0]      rd_b_full;
  logic [IDX_W-1:0] rd_a_idx;
  logic [IDX_W-1:0] rd_b_idx;

  logic             active_q;
  logic [CNT_W-1:0] i_q;
  logic [CNT_W-1:0] j_q;
  logic [CNT_W-1:0] k_q;
  logic [DIM_W-1:0] m_q;
  logic [DIM_W-1:0] p_q;
  logic [DIM_W-1:0] n_q;
  logic             k_end;
  logic             j_end;
  logic             i_end;
  tag_t             issue_tag;
  tag_t             s1_tag_q;
  mac_status_t      mac_status;
  logic             advance;

  // Size register as used by a sweep: 0 counts as 1, large values as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // Configuration registers; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CFG_RESET;
      inner_dim_q <= CFG_RESET;
      cols_b_q    <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input words are taken whenever no sweep is running or draining.
  assign busy       = active_q | s1_tag_q.valid | mac_status.busy;
  assign in_ready_o = ~busy;
  assign in_accept  = in_valid_i & in_ready_o;

  // Element load address and value.
  assign wr_full     = 32'(in_data_i.elem_row) * 32'(MAX_DIM) + 32'(in_data_i.elem_col);
  assign wr_idx      = wr_full[IDX_W-1:0];
  assign wr_in_range = (32'(in_data_i.elem_row) < 32'(MAX_DIM)) &&
                       (32'(in_data_i.elem_col) < 32'(MAX_DIM));
  assign wr_value    = ELEM_WIDTH'(in_data_i.elem_value);

  // Sweep position: k runs fastest, then the column j, then the row i.
  assign k_end = (DIM_W'(k_q) == p_q - DIM_W'(1));
  assign j_end = (DIM_W'(j_q) == n_q - DIM_W'(1));
  assign i_end = (DIM_W'(i_q) == m_q - DIM_W'(1));

  assign advance = active_q & ~mac_status.stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
    end else if (in_accept && (in_data_i.operation == OP_COMPUTE)) begin
      active_q <= 1'b1;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
    end else if (advance) begin
      if (!k_end) begin
        k_q <= k_q + CNT_W'(1);
      end else begin
        k_q <= '0;
        if (!j_end) begin
          j_q <= j_q + CNT_W'(1);
        end else begin
          j_q <= '0;
          if (!i_end) begin
            i_q <= i_q + CNT_W'(1);
          end else begin
            active_q <= 1'b0;
          end
        end
      end
    end
  end

  // Sizes are fixed for the length of a sweep.
  always_ff @(posedge clk_i) begin
    if (in_accept && (in_data_i.operation == OP_COMPUTE)) begin
      m_q <= clamp_dim(rows_a_q);
      p_q <= clamp_dim(inner_dim_q);
      n_q <= clamp_dim(cols_b_q);
    end
  end

  // Read addresses: A[i][k] and B[k][j].
  assign rd_a_full = 32'(i_q) * 32'(MAX_DIM) + 32'(k_q);
  assign rd_b_full = 32'(k_q) * 32'(MAX_DIM) + 32'(j_q);
  assign rd_a_idx  = rd_a_full[IDX_W-1:0];
  assign rd_b_idx  = rd_b_full[IDX_W-1:0];

  // Element memories: one write port for loads, one registered read port for the sweep.
  // A stalled read keeps its data, so the memory output lines up with the held stage.
  always_ff @(posedge clk_i) begin
    if (in_accept && wr_in_range && (in_data_i.operation == OP_LOAD_A)) begin
      mem_a[wr_idx] <= wr_value;
    end
    if (!mac_status.stall) begin
      rd_a_q <= mem_a[rd_a_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && wr_in_range && (in_data_i.operation == OP_LOAD_B)) begin
      mem_b[wr_idx] <= wr_value;
    end
    if (!mac_status.stall) begin
      rd_b_q <= mem_b[rd_b_idx];
    end
  end

  // Control that follows the read data into the datapath.
  always_comb begin
    issue_tag.valid  = active_q;
    issue_tag.first  = (k_q == '0);
    issue_tag.last_k = k_end;
    issue_tag.last   = k_end & j_end & i_end;
    issue_tag.row    = ROW_W'(i_q);
    issue_tag.col    = COL_W'(j_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else if (!mac_status.stall) begin
      s1_tag_q <= issue_tag;
    end
  end

  matmul_mac #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (s1_tag_q),
    .a_i         (rd_a_q),
    .b_i         (rd_b_q),
    .status_o    (mac_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Checks on the sweep sequencer.
  `MM_ASSERT_NEXT(a_compute_starts, in_accept && (in_data_i.operation == OP_COMPUTE), active_q, "compute word did not start a sweep")
  `MM_ASSERT_IMP(a_last_ends_sweep, s1_tag_q.valid && s1_tag_q.last, !active_q, "sweep still running after its final step")
  `MM_ASSERT_NEXT(a_stall_holds, active_q && mac_status.stall, active_q && $stable(i_q) && $stable(j_q) && $stable(k_q), "sweep moved while stalled")

endmodule

`default_nettype wire
